// File: src/infix_to_postfix_converter_macros.svh
// Assertion helpers for the infix to postfix converter.
`ifndef INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ITP_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("itp assertion failed");

// Next-cycle implication, checked out of reset.
`define ITP_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("itp assertion failed");

`endif

// File: src/itp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package itp_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int OP_W        = 3;

    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_ADD   = 8'h2B;
    localparam logic [7:0] CH_SUB   = 8'h2D;
    localparam logic [7:0] CH_DIV   = 8'h2F;

    typedef enum logic [OP_W-1:0] {
        OP_OPEN = 3'd0,
        OP_MUL  = 3'd1,
        OP_DIV  = 3'd2,
        OP_ADD  = 3'd3,
        OP_SUB  = 3'd4
    } op_code_t;

    typedef enum logic [1:0] {
        ST_SYMBOL   = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_UNMATCH  = 2'd2,
        ST_END_ONLY = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CL_OPERAND,
        CL_OPEN,
        CL_CLOSE,
        CL_MULDIV,
        CL_ADDSUB
    } sym_class_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_PUSH,
        S_FLUSH,
        S_FINISH
    } state_t;

    function automatic sym_class_t classify(input logic [7:0] ch);
        sym_class_t c;
        case (ch) inside
            CH_OPEN:         c = CL_OPEN;
            CH_CLOSE:        c = CL_CLOSE;
            CH_MUL, CH_DIV:  c = CL_MULDIV;
            CH_ADD, CH_SUB:  c = CL_ADDSUB;
            default:         c = CL_OPERAND;
        endcase
        return c;
    endfunction

    function automatic op_code_t op_of(input logic [7:0] ch);
        op_code_t c;
        case (ch)
            CH_MUL:  c = OP_MUL;
            CH_DIV:  c = OP_DIV;
            CH_ADD:  c = OP_ADD;
            CH_SUB:  c = OP_SUB;
            default: c = OP_OPEN;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] op_char(input op_code_t op);
        logic [7:0] ch;
        unique case (op)
            OP_OPEN: ch = CH_OPEN;
            OP_MUL:  ch = CH_MUL;
            OP_DIV:  ch = CH_DIV;
            OP_ADD:  ch = CH_ADD;
            OP_SUB:  ch = CH_SUB;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// File: src/itp_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: src/infix_to_postfix_converter.sv
// Infix to postfix converter (shunting-yard), one ASCII character per request.
// Input: s_tdata carries the character, s_tlast marks the last character of an
// expression; at that character the operator stack is flushed.
// Output: m_tdata is the postfix character, m_tuser holds the status and the
// end-of-expression flag, m_tlast marks the last result of one request.
// Requests are taken one at a time: s_tready is high only when the block is
// idle. An open bracket is pushed, a close bracket pops down to its match and
// any other operator pops, then is pushed; the last character of an expression
// then flushes the stack. The operator stack lives in a 16-entry RAM with
// registered read, read one entry per cycle at the top. Results go through a
// one-entry holding slot (needed to tag the last one) into the output register;
// a stalled receiver halts popping, nothing drops. An operand result enters the
// holding slot on accept and is offered once the request finishes; any other
// result is offered once the next result is produced or the request finishes.
// Reset empties the stack, clears all valids and returns to idle.
`timescale 1ns / 1ps
`default_nettype none
`include "infix_to_postfix_converter_macros.svh"

module infix_to_postfix_converter (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] symbol_in
    input  wire logic       s_tlast,   // expr_end
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic      [7:0] m_tdata,   // [7:0] symbol_out
    output logic      [2:0] m_tuser,   // [1:0] status, [2] expr_done
    output logic            m_tlast    // run_last
);

    localparam int AW = itp_pkg::ADDR_W;
    localparam int CW = itp_pkg::CNT_W;

    itp_pkg::state_t     state_reg, state_next;
    itp_pkg::sym_class_t cls_reg;
    itp_pkg::op_code_t   code_reg;
    logic                last_reg;
    logic [CW-1:0]       count_reg, count_next;

    logic                pend_valid_reg;
    logic [7:0]          pend_sym_reg;
    itp_pkg::status_t    pend_status_reg;

    logic                out_valid_reg;
    logic [7:0]          out_sym_reg;
    itp_pkg::status_t    out_status_reg;
    logic                out_last_reg;
    logic                out_done_reg;

    logic                fwd_hit_reg;
    logic [2:0]          fwd_data_reg;

    logic [2:0]          ram_rd_data;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    itp_pkg::op_code_t   top;

    logic                out_free;
    logic                emit_ok;
    logic                emit;
    logic [7:0]          emit_sym;
    itp_pkg::status_t    emit_status;
    logic                cnt_dec;
    logic                cnt_inc;
    logic                wr_en;
    logic                fin;
    logic                accept;
    logic                pop_match;
    logic                empty;
    logic                full;
    itp_pkg::sym_class_t in_cls;

    assign out_free = !out_valid_reg || m_tready;
    assign emit_ok  = !pend_valid_reg || out_free;
    assign empty    = (count_reg == '0);
    assign full     = (count_reg >= CW'(itp_pkg::STACK_DEPTH));
    assign in_cls   = itp_pkg::classify(s_tdata);
    assign top      = itp_pkg::op_code_t'(fwd_hit_reg ? fwd_data_reg : ram_rd_data);

    always_comb begin
        if (cls_reg == itp_pkg::CL_MULDIV) begin
            pop_match = (top == itp_pkg::OP_MUL) || (top == itp_pkg::OP_DIV);
        end else begin
            pop_match = (top != itp_pkg::OP_OPEN);
        end
    end

    // control outputs
    always_comb begin
        emit        = 1'b0;
        emit_sym    = 8'h00;
        emit_status = itp_pkg::ST_SYMBOL;
        cnt_dec     = 1'b0;
        cnt_inc     = 1'b0;
        wr_en       = 1'b0;
        fin         = 1'b0;
        accept      = 1'b0;
        unique case (state_reg)
            itp_pkg::S_IDLE: begin
                accept = s_tvalid;
                if (s_tvalid && in_cls == itp_pkg::CL_OPERAND) begin
                    emit     = 1'b1;
                    emit_sym = s_tdata;
                end
            end
            itp_pkg::S_POP: begin
                if (empty) begin
                    if (cls_reg == itp_pkg::CL_CLOSE && emit_ok) begin
                        emit        = 1'b1;
                        emit_status = itp_pkg::ST_UNMATCH;
                    end
                end else if (pop_match) begin
                    if (emit_ok) begin
                        emit     = 1'b1;
                        emit_sym = itp_pkg::op_char(top);
                        cnt_dec  = 1'b1;
                    end
                end else if (cls_reg == itp_pkg::CL_CLOSE) begin
                    cnt_dec = 1'b1;
                end
            end
            itp_pkg::S_FLUSH: begin
                if (!empty) begin
                    if (top == itp_pkg::OP_OPEN) begin
                        cnt_dec = 1'b1;
                    end else if (emit_ok) begin
                        emit     = 1'b1;
                        emit_sym = itp_pkg::op_char(top);
                        cnt_dec  = 1'b1;
                    end
                end
            end
            itp_pkg::S_PUSH: begin
                if (full) begin
                    if (emit_ok) begin
                        emit        = 1'b1;
                        emit_status = itp_pkg::ST_OVERFLOW;
                    end
                end else begin
                    wr_en   = 1'b1;
                    cnt_inc = 1'b1;
                end
            end
            itp_pkg::S_FINISH: begin
                if (!(last_reg && !empty)) begin
                    fin = out_free || !(pend_valid_reg || last_reg);
                end
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            itp_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    unique case (in_cls)
                        itp_pkg::CL_OPERAND: state_next = itp_pkg::S_FINISH;
                        itp_pkg::CL_OPEN:    state_next = itp_pkg::S_PUSH;
                        default:             state_next = itp_pkg::S_POP;
                    endcase
                end
            end
            itp_pkg::S_POP: begin
                if (empty) begin
                    if (cls_reg != itp_pkg::CL_CLOSE) begin
                        state_next = itp_pkg::S_PUSH;
                    end else if (emit) begin
                        state_next = itp_pkg::S_FINISH;
                    end
                end else if (!pop_match) begin
                    state_next = (cls_reg == itp_pkg::CL_CLOSE) ? itp_pkg::S_FINISH
                                                                : itp_pkg::S_PUSH;
                end
            end
            itp_pkg::S_FLUSH: begin
                if (empty) begin
                    state_next = itp_pkg::S_FINISH;
                end
            end
            itp_pkg::S_PUSH: begin
                if (!full || emit) begin
                    state_next = itp_pkg::S_FINISH;
                end
            end
            itp_pkg::S_FINISH: begin
                if (last_reg && !empty) begin
                    state_next = itp_pkg::S_FLUSH;
                end else if (fin) begin
                    state_next = itp_pkg::S_IDLE;
                end
            end
            default: state_next = itp_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        count_next = count_reg;
        if (cnt_dec) begin
            count_next = count_reg - CW'(1);
        end else if (cnt_inc) begin
            count_next = count_reg + CW'(1);
        end
    end

    // read the entry that will be the top next cycle
    assign rd_addr = AW'(count_next - CW'(1));
    assign wr_addr = AW'(count_reg);

    itp_ram #(
        .WIDTH(itp_pkg::OP_W),
        .DEPTH(itp_pkg::STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (code_reg),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= itp_pkg::S_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            fwd_hit_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
            if (emit) begin
                pend_valid_reg <= 1'b1;
                if (pend_valid_reg) begin
                    out_valid_reg <= 1'b1;
                end else if (m_tready) begin
                    out_valid_reg <= 1'b0;
                end
            end else if (fin && (pend_valid_reg || last_reg)) begin
                pend_valid_reg <= 1'b0;
                out_valid_reg  <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        fwd_data_reg <= code_reg;
        if (accept) begin
            cls_reg  <= in_cls;
            code_reg <= itp_pkg::op_of(s_tdata);
            last_reg <= s_tlast;
        end
        if (emit) begin
            pend_sym_reg    <= emit_sym;
            pend_status_reg <= emit_status;
            if (pend_valid_reg) begin
                out_sym_reg    <= pend_sym_reg;
                out_status_reg <= pend_status_reg;
                out_last_reg   <= 1'b0;
                out_done_reg   <= 1'b0;
            end
        end else if (fin && (pend_valid_reg || last_reg)) begin
            out_sym_reg    <= pend_valid_reg ? pend_sym_reg : 8'h00;
            out_status_reg <= pend_valid_reg ? pend_status_reg : itp_pkg::ST_END_ONLY;
            out_last_reg   <= 1'b1;
            out_done_reg   <= last_reg;
        end
    end

    assign s_tready = (state_reg == itp_pkg::S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sym_reg;
    assign m_tuser  = {out_done_reg, out_status_reg};
    assign m_tlast  = out_last_reg;

    `ITP_ASSERT_IMP(a_idle_no_pending, aclk, aresetn, s_tready, !pend_valid_reg)
    `ITP_ASSERT_NXT(a_accept_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `ITP_ASSERT_IMP(a_push_room, aclk, aresetn, wr_en, count_reg < CW'(itp_pkg::STACK_DEPTH))
    `ITP_ASSERT_IMP(a_emit_room, aclk, aresetn, emit && pend_valid_reg, out_free)

endmodule

`default_nettype wire

// File: tb/infix_to_postfix_converter_test.sv
`timescale 1ns / 1ps

module infix_to_postfix_converter_test;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } char_req_t;

    typedef struct {
        logic [7:0]       sym;
        itp_pkg::status_t status;
        logic             run_last;
        logic             expr_done;
    } postfix_rec_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [2:0] m_tuser;
    logic       m_tlast;

    char_req_t    char_q[$];
    postfix_rec_t postfix_q[$];
    postfix_rec_t step_out[$];

    // operator stack holds the operator characters themselves
    logic [7:0] op_chars[itp_pkg::STACK_DEPTH];
    int         op_cnt = 0;

    int cyc = 0;
    int errors = 0;
    int reqs_sent = 0;
    int results_seen = 0;
    int n_overflow = 0;
    int n_unmatch = 0;
    int n_end_only = 0;
    logic calm;

    infix_to_postfix_converter u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // no idling on either side inside this window
    assign calm = (cyc >= 600) && (cyc < 1400);

    function automatic logic is_operator(logic [7:0] ch);
        return ch == itp_pkg::CH_OPEN || ch == itp_pkg::CH_CLOSE ||
               ch == itp_pkg::CH_MUL || ch == itp_pkg::CH_DIV ||
               ch == itp_pkg::CH_ADD || ch == itp_pkg::CH_SUB;
    endfunction

    function automatic void emit_rec(logic [7:0] ch, itp_pkg::status_t st);
        postfix_rec_t r;
        r.sym       = ch;
        r.status    = st;
        r.run_last  = 1'b0;
        r.expr_done = 1'b0;
        step_out.push_back(r);
        case (st)
            itp_pkg::ST_OVERFLOW: n_overflow++;
            itp_pkg::ST_UNMATCH:  n_unmatch++;
            itp_pkg::ST_END_ONLY: n_end_only++;
            default: ;
        endcase
    endfunction

    function automatic void pop_op();
        emit_rec(op_chars[op_cnt - 1], itp_pkg::ST_SYMBOL);
        op_cnt--;
    endfunction

    function automatic void push_op(logic [7:0] ch);
        if (op_cnt >= itp_pkg::STACK_DEPTH) begin
            emit_rec(8'h00, itp_pkg::ST_OVERFLOW);
        end else begin
            op_chars[op_cnt] = ch;
            op_cnt++;
        end
    endfunction

    function automatic void shunt_symbol(logic [7:0] ch, logic last);
        int k;
        case (ch) inside
            itp_pkg::CH_OPEN: push_op(ch);
            itp_pkg::CH_CLOSE: begin
                while (op_cnt > 0 && op_chars[op_cnt - 1] != itp_pkg::CH_OPEN) pop_op();
                if (op_cnt > 0) op_cnt--;
                else emit_rec(8'h00, itp_pkg::ST_UNMATCH);
            end
            itp_pkg::CH_MUL, itp_pkg::CH_DIV: begin
                while (op_cnt > 0 && (op_chars[op_cnt - 1] == itp_pkg::CH_MUL ||
                                      op_chars[op_cnt - 1] == itp_pkg::CH_DIV)) pop_op();
                push_op(ch);
            end
            itp_pkg::CH_ADD, itp_pkg::CH_SUB: begin
                while (op_cnt > 0 && op_chars[op_cnt - 1] != itp_pkg::CH_OPEN) pop_op();
                push_op(ch);
            end
            default: emit_rec(ch, itp_pkg::ST_SYMBOL);
        endcase
        if (last) begin
            while (op_cnt > 0) begin
                if (op_chars[op_cnt - 1] == itp_pkg::CH_OPEN) op_cnt--;
                else pop_op();
            end
            if (step_out.size() == 0) emit_rec(8'h00, itp_pkg::ST_END_ONLY);
            k = step_out.size() - 1;
            step_out[k].expr_done = 1'b1;
        end
        if (step_out.size() > 0) begin
            k = step_out.size() - 1;
            step_out[k].run_last = 1'b1;
        end
        foreach (step_out[i]) postfix_q.push_back(step_out[i]);
        step_out.delete();
    endfunction

    task automatic queue_char(logic [7:0] ch, logic last);
        char_req_t r;
        r.ch   = ch;
        r.last = last;
        char_q.push_back(r);
    endtask

    function automatic logic [7:0] rand_operand();
        logic [7:0] ch;
        if ($urandom_range(0, 3) == 0) begin
            ch = 8'($urandom_range(0, 255));
            while (is_operator(ch)) ch = 8'($urandom_range(0, 255));
        end else if ($urandom_range(0, 1) == 0) begin
            ch = 8'h61 + 8'($urandom_range(0, 25));
        end else begin
            ch = 8'h30 + 8'($urandom_range(0, 9));
        end
        return ch;
    endfunction

    function automatic logic [7:0] rand_op();
        case ($urandom_range(0, 3))
            0: return itp_pkg::CH_MUL;
            1: return itp_pkg::CH_DIV;
            2: return itp_pkg::CH_ADD;
            default: return itp_pkg::CH_SUB;
        endcase
    endfunction

    task automatic gen_expression();
        int depth;
        int terms;
        depth = 0;
        terms = $urandom_range(1, 8);
        for (int n = 0; n < terms; n++) begin
            while ($urandom_range(0, 3) == 0 && depth < 6) begin
                queue_char(itp_pkg::CH_OPEN, 1'b0);
                depth++;
            end
            queue_char(rand_operand(), 1'b0);
            while (depth > 0 && $urandom_range(0, 2) == 0) begin
                queue_char(itp_pkg::CH_CLOSE, 1'b0);
                depth--;
            end
            if (n < terms - 1) queue_char(rand_op(), 1'b0);
        end
        // sometimes leave open brackets for the flush to discard
        while (depth > 0 && $urandom_range(0, 4) != 0) begin
            queue_char(itp_pkg::CH_CLOSE, 1'b0);
            depth--;
        end
        char_q[char_q.size() - 1].last = 1'b1;
    endtask

    task automatic gen_deep_nest();
        int depth;
        int closes;
        depth = $urandom_range(12, 20);
        repeat (depth) begin
            if ($urandom_range(0, 3) == 0) begin
                queue_char(rand_operand(), 1'b0);
                queue_char(rand_op(), 1'b0);
            end
            queue_char(itp_pkg::CH_OPEN, 1'b0);
        end
        queue_char(rand_operand(), 1'b0);
        closes = $urandom_range(0, depth + 2);
        repeat (closes) queue_char(itp_pkg::CH_CLOSE, 1'b0);
        char_q[char_q.size() - 1].last = 1'b1;
    endtask

    task automatic gen_noise();
        repeat ($urandom_range(1, 6))
            queue_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    endtask

    initial begin
        queue_char(8'h00, 1'b0);
        queue_char("a", 1'b0);
        queue_char(itp_pkg::CH_MUL, 1'b0);
        queue_char("b", 1'b0);
        queue_char(itp_pkg::CH_DIV, 1'b0);
        queue_char("c", 1'b0);
        queue_char(itp_pkg::CH_ADD, 1'b0);
        queue_char(itp_pkg::CH_OPEN, 1'b0);
        queue_char(8'hFF, 1'b0);
        queue_char(itp_pkg::CH_SUB, 1'b0);
        queue_char("d", 1'b0);
        queue_char(itp_pkg::CH_CLOSE, 1'b0);
        queue_char(itp_pkg::CH_CLOSE, 1'b0);
        queue_char("e", 1'b1);
        queue_char(itp_pkg::CH_OPEN, 1'b1);
        queue_char(itp_pkg::CH_ADD, 1'b1);
        queue_char(itp_pkg::CH_CLOSE, 1'b1);
        queue_char(itp_pkg::CH_OPEN, 1'b0);
        queue_char(itp_pkg::CH_OPEN, 1'b0);
        queue_char("x", 1'b0);
        queue_char(itp_pkg::CH_MUL, 1'b1);
        while (char_q.size() < 330) begin
            case ($urandom_range(0, 9))
                0, 1: gen_noise();
                2:    gen_deep_nest();
                default: gen_expression();
            endcase
        end
    end

    initial begin
        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
    end

    always @(posedge aclk) begin
        cyc <= cyc + 1;
    end

    // request driver
    always @(posedge aclk) begin : driver
        char_req_t r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tlast  <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (char_q.size() > 0 && (calm || $urandom_range(0, 99) >= 25)) begin
                r = char_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= r.ch;
                s_tlast  <= r.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= calm || $urandom_range(0, 99) >= 25;
    end

    // monitor: predict on accepted requests, check results in order
    always @(posedge aclk) begin : monitor
        postfix_rec_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                reqs_sent++;
                shunt_symbol(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (postfix_q.size() == 0) begin
                    if (errors < 10)
                        $display("%0t: unexpected result data=%02h user=%h last=%b",
                                 $realtime, m_tdata, m_tuser, m_tlast);
                    errors++;
                end else begin
                    want = postfix_q.pop_front();
                    if (m_tdata !== want.sym || m_tuser[1:0] !== want.status ||
                        m_tuser[2] !== want.expr_done || m_tlast !== want.run_last) begin
                        if (errors < 10)
                            $display({"%0t: mismatch exp sym=%02h st=%0d done=%b last=%b,",
                                      " got sym=%02h st=%0d done=%b last=%b"},
                                     $realtime, want.sym, want.status, want.expr_done,
                                     want.run_last, m_tdata, m_tuser[1:0], m_tuser[2],
                                     m_tlast);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        @(posedge aresetn);
        while (char_q.size() != 0 || s_tvalid) @(posedge aclk);
        while (postfix_q.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        $display("Sent %0d characters, checked %0d postfix results", reqs_sent, results_seen);
        $display("Status hits: %0d overflow, %0d unmatched close, %0d end-only",
                 n_overflow, n_unmatch, n_end_only);
        if (errors == 0) begin
            $display("** infix_to_postfix_converter: PASSED **");
        end else begin
            $display("%0d mismatches", errors);
            $display("** infix_to_postfix_converter: FAILED **");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timeout with %0d results outstanding", postfix_q.size());
        $display("** infix_to_postfix_converter: FAILED **");
        $finish;
    end

endmodule
